// ===== hw/rtl/fsip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fsip_pkg;

  localparam int SITE_W = 5;
  localparam int TGT_N  = 32;
  localparam int OCC_W  = 32;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                valid;
    logic                func;
    logic [SITE_W-1:0]   site;
    logic [SITE_W-1:0]   target;
    logic [OCC_W-1:0]    occupancy;
    logic [TGT_N-1:0]    seen;
    logic                parity;
  } fsip_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fsip_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fsip_cell #(
  parameter int IDX = 0
) (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic en,
  input  wire  fsip_pkg::fsip_word_t item_i,
  output fsip_pkg::fsip_word_t     item_o
);

  localparam logic [6:0] IDX_L = 7'(IDX);

  logic [fsip_pkg::SITE_W-1:0] perm_r;
  logic [fsip_pkg::SITE_W-1:0] perm_nxt;
  fsip_pkg::fsip_word_t        item_r;
  fsip_pkg::fsip_word_t        item_nxt;
  logic                        occ_bit;
  logic                        hit;
  logic                        occupied;
  logic [fsip_pkg::TGT_N-1:0]  above;
  logic [fsip_pkg::TGT_N-1:0]  own;

  if (IDX < fsip_pkg::OCC_W) begin : g_occ
    assign occ_bit = item_i.occupancy[IDX];
  end else begin : g_no_occ
    assign occ_bit = 1'b0;
  end

  always_comb begin
    hit      = item_i.valid && (item_i.func == fsip_pkg::FUNC_LOAD)
               && ({2'b00, item_i.site} == IDX_L);
    occupied = item_i.valid && (item_i.func == fsip_pkg::FUNC_QUERY) && occ_bit;
    perm_nxt = hit ? item_i.target : perm_r;
    above    = {{(fsip_pkg::TGT_N-1){1'b1}}, 1'b0} << perm_r;
    own      = {{(fsip_pkg::TGT_N-1){1'b0}}, 1'b1} << perm_r;
    item_nxt = item_i;
    if (occupied) begin
      item_nxt.parity = item_i.parity ^ (^(item_i.seen & above));
      item_nxt.seen   = item_i.seen ^ own;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      perm_r <= perm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r <= '0;
    end else if (en) begin
      item_r <= item_nxt;
    end
  end

  assign item_o = item_r;

endmodule

`default_nettype wire

// ===== hw/rtl/fermion_sign_inversion_parity_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one word per cycle; a load or query may enter each cycle in_stall is low.
// One cell per site holds that site's target; each word walks the chain.
// in_stall follows a stalled result word at the output stage.
// Reset (rst_n low, synchronous) empties the chain; the table is undefined until written.
module fermion_sign_inversion_parity_unit #(
  parameter int SITES = 32
) (
  input  wire  logic                          clk,
  input  wire  logic                          rst_n,
  input  wire  logic                          in_valid,
  output logic                                in_stall,
  input  wire  logic                          in_func,
  input  wire  logic [fsip_pkg::SITE_W-1:0]   in_site,
  input  wire  logic [fsip_pkg::SITE_W-1:0]   in_target,
  input  wire  logic [fsip_pkg::OCC_W-1:0]    in_occupancy,
  output logic                                out_valid,
  input  wire  logic                          out_stall,
  output logic                                out_negative
);

  fsip_pkg::fsip_word_t chain [SITES+1];
  fsip_pkg::fsip_word_t word_in;
  logic                 en;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_comb begin
    word_in           = '0;
    word_in.valid     = in_valid;
    word_in.func      = in_func;
    word_in.site      = in_site;
    word_in.target    = in_target;
    word_in.occupancy = in_occupancy;
  end

  assign chain[0] = word_in;

  for (genvar i = 0; i < SITES; i++) begin : g_cell
    fsip_cell #(
      .IDX(i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .item_i(chain[i]),
      .item_o(chain[i+1])
    );
  end

  assign out_valid    = chain[SITES].valid && (chain[SITES].func == fsip_pkg::FUNC_QUERY);
  assign out_negative = chain[SITES].parity;

`ifndef SYNTHESIS
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> g_cell[0].u_cell.item_r.valid)
    else $error("accepted word missing from first cell");

  a_empty_even: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (chain[SITES].occupancy == '0)) |-> !out_negative)
    else $error("negative sign with no occupied site");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(chain[SITES]))
    else $error("output stage moved while stalled");
`endif

endmodule

`default_nettype wire
